[rtl/mersenne_twister_generator_defines.svh]
// Assertion macros shared by the generator's RTL.
`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// Antecedent and consequent in the same cycle.
`define MTG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtg assertion failed");
// Consequent in the cycle after the antecedent.
`define MTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtg assertion failed");
`else
`define MTG_ASSERT_SAME(label, clk, rst, ante, cons)
`define MTG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/mtg_pkg.sv]
package mtg_pkg;

   localparam int TABLE_LENGTH = 624;
   localparam int TWIST_OFFSET = 397;
   // Position of the far partner in the sliding window of the state sequence.
   localparam int TWIST_TAP = TWIST_OFFSET % TABLE_LENGTH;
   localparam int FILL_COUNT_WIDTH = $clog2(TABLE_LENGTH);

   typedef logic [31:0] word_type;
   typedef logic [FILL_COUNT_WIDTH-1:0] fill_count_type;

   localparam word_type MATRIX_A   = 32'h9908b0df;
   localparam word_type TEMPER_B   = 32'h9d2c5680;
   localparam word_type TEMPER_C   = 32'hefc60000;
   localparam word_type HIGH_BIT   = 32'h80000000;
   localparam word_type LOW_BITS   = 32'h7fffffff;
   localparam word_type SEED_MULT  = 32'd6069;
   localparam word_type SEED_RESET = 32'd4357;

   typedef struct packed {
      logic     busy;
      word_type word;
   } fill_status_type;

   // Next word of the sequence from the oldest word, its successor and the far partner.
   function automatic word_type twist_word(word_type first, word_type second, word_type far);
      word_type y;
      word_type w;
      y = (first & HIGH_BIT) | (second & LOW_BITS);
      w = far ^ (y >> 1);
      if (y[0]) begin
         w = w ^ MATRIX_A;
      end
      return w;
   endfunction

   function automatic word_type temper(word_type value);
      word_type y;
      y = value;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

[rtl/mersenne_twister_generator.sv]
// Mersenne Twister word generator (mt19937 recurrence, multiplicative seeding).
// Input channel req_*: each accepted item with req_draw_request set yields one
// tempered 32-bit word on rsp_*; an item with the bit clear is taken and dropped.
// Config port csr_*: a write of csr_seed_value restarts the table fill from it.
// The state lives in a row of 624 one-word cells that shift by one position per
// step; the new word enters at the tail and is computed from the head, its
// neighbor and the far partner cell.
// The result is in the output register in the cycle after acceptance.
// Throughput: one item per cycle unless filling or stalled (one row step each).
// After reset and after every seed write the block fills the row, one table
// word per step from the seeding multiplier; req_ready stays low during that
// fill.
// When the receiver stalls, the result is held and req_ready drops until the
// held item is taken; req_ready follows rsp_ready in the same cycle.
`include "mersenne_twister_generator_defines.svh"

module mersenne_twister_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_draw_request,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mtg_pkg::word_type rsp_random_word,
   input  logic              csr_write_enable,
   input  mtg_pkg::word_type csr_seed_value
);
   import mtg_pkg::*;

   fill_status_type fill_status;
   word_type        cell_word [TABLE_LENGTH];
   word_type        tail_word;
   word_type        new_word;
   logic            shift_en;
   logic            accept;
   logic            draw;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   word_type        rsp_word_ff;

   mtg_seeder u_seeder (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_seed_value   (csr_seed_value),
      .fill_status      (fill_status)
   );

   assign new_word  = twist_word(cell_word[0], cell_word[1], cell_word[TWIST_TAP]);
   assign tail_word = fill_status.busy ? fill_status.word : new_word;

   assign req_ready = !fill_status.busy && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign draw      = accept && req_draw_request;
   assign shift_en  = fill_status.busy || draw;

   for (genvar i = 0; i < TABLE_LENGTH; i++) begin : g_cell
      if (i == TABLE_LENGTH - 1) begin : g_tail
         mtg_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .data_in  (tail_word),
            .data_out (cell_word[i])
         );
      end else begin : g_body
         mtg_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .data_in  (cell_word[i+1]),
            .data_out (cell_word[i])
         );
      end
   end

   always_comb begin
      priority if (draw) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (draw) begin
         rsp_word_ff <= temper(new_word);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   `MTG_ASSERT_SAME(a_no_accept_while_filling, clock, reset, fill_status.busy, !req_ready)
   `MTG_ASSERT_NEXT(a_draw_gives_result, clock, reset, draw, rsp_valid)
   `MTG_ASSERT_NEXT(a_seed_write_starts_fill, clock, reset, csr_write_enable, fill_status.busy)
   `MTG_ASSERT_NEXT(a_fill_loads_seed, clock, reset, csr_write_enable,
      fill_status.word == $past(csr_seed_value))

endmodule

[rtl/mtg_cell.sv]
module mtg_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  mtg_pkg::word_type data_in,
   output mtg_pkg::word_type data_out
);
   import mtg_pkg::*;

   word_type data_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

[rtl/mtg_seeder.sv]
module mtg_seeder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  mtg_pkg::word_type       csr_seed_value,
   output mtg_pkg::fill_status_type fill_status
);
   import mtg_pkg::*;

   logic           busy_ff;
   logic           busy_in;
   fill_count_type count_ff;
   fill_count_type count_in;
   word_type       word_ff;
   word_type       word_in;
   logic           last;

   assign last = (count_ff == FILL_COUNT_WIDTH'(TABLE_LENGTH - 1));

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      word_in  = word_ff;
      if (csr_write_enable) begin
         busy_in  = 1'b1;
         count_in = '0;
         word_in  = csr_seed_value;
      end else if (busy_ff) begin
         // One table word leaves per cycle; the next is the product with the multiplier.
         busy_in  = !last;
         count_in = count_ff + 1'b1;
         word_in  = word_ff * SEED_MULT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
         word_ff  <= SEED_RESET;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
         word_ff  <= word_in;
      end
   end

   assign fill_status.busy = busy_ff;
   assign fill_status.word = word_ff;

endmodule

[verif/mersenne_twister_generator_tb.sv]
`timescale 1ns / 100ps

module mersenne_twister_generator_tb;

   import mtg_pkg::*;

   localparam int TABLE_WORDS = 624;
   localparam int SHIFT_DISTANCE = 397;
   localparam word_type TWIST_MATRIX = 32'h9908b0df;
   localparam word_type TEMPER_MASK_B = 32'h9d2c5680;
   localparam word_type TEMPER_MASK_C = 32'hefc60000;
   localparam word_type FILL_MULTIPLIER = 32'd6069;
   localparam word_type SEED_DEFAULT = 32'd4357;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 20;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_draw_request;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   word_type rsp_random_word;
   logic csr_write_enable;
   word_type csr_seed_value;

   // Shadow copy of the generator state.
   word_type word_table [TABLE_WORDS];
   int unsigned read_index = TABLE_WORDS;
   bit seed_pending = 1'b1;
   word_type seed_reg = SEED_DEFAULT;

   word_type expected_words [$];
   word_type expected_word;
   int error_count = 0;
   int words_checked = 0;
   int seed_writes = 0;
   int sender_idle_pct = 19;
   int receiver_idle_pct = 45;

   mersenne_twister_generator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_draw_request (req_draw_request),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_word  (rsp_random_word),
      .csr_write_enable (csr_write_enable),
      .csr_seed_value   (csr_seed_value)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void fill_words_from_seed();
      int i;
      word_table[0] = seed_reg;
      for (i = 1; i < TABLE_WORDS; i++) begin
         word_table[i] = FILL_MULTIPLIER * word_table[i - 1];
      end
   endfunction

   // The table is regenerated in place, so late entries see partners that
   // were already rewritten in this pass.
   function automatic void twist_words();
      int k;
      word_type mixed;
      for (k = 0; k < TABLE_WORDS; k++) begin
         mixed = {word_table[k][31], word_table[(k + 1) % TABLE_WORDS][30:0]};
         word_table[k] = word_table[(k + SHIFT_DISTANCE) % TABLE_WORDS] ^ (mixed >> 1)
            ^ (mixed[0] ? TWIST_MATRIX : 32'd0);
      end
   endfunction

   function automatic word_type tempered(word_type raw);
      word_type t;
      t = raw ^ (raw >> 11);
      t = t ^ ((t << 7) & TEMPER_MASK_B);
      t = t ^ ((t << 15) & TEMPER_MASK_C);
      return t ^ (t >> 18);
   endfunction

   function automatic word_type next_random_word();
      word_type drawn;
      if (seed_pending) begin
         fill_words_from_seed();
         twist_words();
         read_index = 0;
         seed_pending = 1'b0;
      end else if (read_index >= TABLE_WORDS) begin
         twist_words();
         read_index = 0;
      end
      drawn = tempered(word_table[read_index]);
      read_index++;
      return drawn;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("random_word: no word expected, got %h", rsp_random_word);
            error_count++;
         end else begin
            expected_word = expected_words.pop_front();
            if (rsp_random_word !== expected_word) begin
               $error("random_word: expected %h, actual %h", expected_word, rsp_random_word);
               error_count++;
            end
            words_checked++;
         end
      end
   end

   task automatic send_item(input logic draw_bit);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_draw_request <= draw_bit;
      do @(posedge clock); while (!req_ready);
      if (draw_bit) begin
         expected_words.push_back(next_random_word());
      end
   endtask

   task automatic wait_for_words();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_seed(input word_type value);
      wait_for_words();
      // A dropped item may still be in flight after the last word has come.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_seed_value <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      seed_reg = value;
      seed_pending = 1'b1;
      seed_writes++;
   endtask

   task automatic random_draws(input int draw_count, input int pause_at);
      int sent;
      sent = 0;
      while (sent < draw_count) begin
         if ($urandom_range(19) == 0) begin
            send_item(1'b0);
         end else begin
            if (sent == pause_at) begin
               wait_for_words();
            end
            send_item(1'b1);
            sent++;
         end
      end
   endtask

   task automatic test_default_seed();
      send_item(1'b0);
      repeat (3) send_item(1'b1);
      send_item(1'b0);
      repeat (2) send_item(1'b1);
   endtask

   task automatic test_seed_extremes();
      word_type extreme_seeds [4];
      int i;
      extreme_seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001};
      for (i = 0; i < 4; i++) begin
         write_seed(extreme_seeds[i]);
         repeat (3) send_item(1'b1);
      end
   endtask

   task automatic test_reseed_between_draws();
      write_seed(32'h1234_5678);
      repeat (2) send_item(1'b1);
      // Two writes in a row: only the second seed should matter.
      write_seed(32'h0000_ffff);
      write_seed(32'hffff_0000);
      repeat (2) send_item(1'b1);
      write_seed(32'hffff_0000);
      repeat (2) send_item(1'b1);
   endtask

   task automatic test_sender_gaps();
      sender_idle_pct = 19;
      receiver_idle_pct = 45;
      write_seed($urandom);
      random_draws(370, -1);
   endtask

   // No reseed here, so the draws run on past the end of the table.
   task automatic test_receiver_stalls();
      sender_idle_pct = 45;
      receiver_idle_pct = 19;
      random_draws(370, 185);
   endtask

   task automatic test_full_rate();
      wait_for_words();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_seed($urandom);
      random_draws(370, -1);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_draw_request <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_seed_value <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_default_seed();
      test_seed_extremes();
      test_reseed_between_draws();
      test_sender_gaps();
      test_receiver_stalls();
      test_full_rate();

      wait_for_words();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d words over %0d seed writes, the reset seed and a table wrap,",
         words_checked, seed_writes);
      $display("with dropped items, sender gaps, receiver stalls and full-rate bursts.");
      if (error_count == 0) begin
         $display("mersenne_twister_generator: match");
      end else begin
         $display("mersenne_twister_generator: mismatch");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Run timed out with %0d words outstanding.", expected_words.size());
      $display("mersenne_twister_generator: mismatch");
      $finish;
   end

endmodule
